// ----- sv/rme_pkg.sv -----
// Shared constants for the modular exponentiation block.
package rme_pkg;

   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 1'b1;

   localparam int EXPONENT_RESET = 3;
   localparam int MODULUS_RESET  = 35;

endpackage

// ----- sv/rme_modmul.sv -----
// Bit-serial interleaved modular multiplier: product = a * b mod modulus.
module rme_modmul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic             active_ff, active_in;
   logic             phase_ff, phase_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] bits_ff, bits_in;
   logic [WIDTH-1:0] acc_ff, acc_in;

   logic [WIDTH:0]   operand;
   logic [WIDTH:0]   modulus_ext;
   logic [WIDTH:0]   reduced;

   // phase 0 doubles acc, phase 1 adds a when the current bit of b is set
   always_comb begin
      modulus_ext = {1'b0, modulus};
      if (phase_ff) begin
         operand = {1'b0, acc_ff} + {1'b0, a_ff};
      end else begin
         operand = {acc_ff, 1'b0};
      end
      if (operand >= modulus_ext) begin
         reduced = operand - modulus_ext;
      end else begin
         reduced = operand;
      end
   end

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      a_in      = a_ff;
      bits_in   = bits_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         phase_in  = 1'b0;
         count_in  = LAST;
         a_in      = a;
         bits_in   = b;
         acc_in    = '0;
      end else if (active_ff) begin
         if (!phase_ff) begin
            acc_in   = reduced[WIDTH-1:0];
            phase_in = 1'b1;
         end else begin
            if (bits_ff[WIDTH-1]) begin
               acc_in = reduced[WIDTH-1:0];
            end
            bits_in  = bits_ff << 1;
            phase_in = 1'b0;
            if (count_ff == '0) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      bits_ff <= bits_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- sv/rsa_modular_exponentiation.sv -----
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// Usage: write exponent (index 0) and modulus (index 1) on the csr_ port while
// busy is low; a write takes effect at the clock edge, no handshake.
// An item (req_message) is accepted at an edge where start is high and busy
// is low. The block answers each item with one rsp_ciphertext, shown for
// exactly one cycle with rsp_valid high; the receiver cannot stall it.
// Operation: first the message is reduced mod modulus, then one step per
// exponent bit, each step running a squaring and a multiplication in two
// bit-serial multipliers side by side. Each multiplication works through the
// multiplier operand one bit at a time, and rsp_valid rises after the last
// step. A modulus below 2 answers 0 in the next cycle. A new item may be
// accepted in the cycle the result is shown, but not while an item is in
// progress (busy high). Reset returns to idle and loads exponent 3,
// modulus 35.
module rsa_modular_exponentiation #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [WORD_WIDTH-1:0]               req_message,
   output logic                                rsp_valid,
   output logic [WORD_WIDTH-1:0]               rsp_ciphertext,
   input  logic                                csr_write_enable,
   input  logic [rme_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]               csr_data
);

   localparam int CW = $clog2(WORD_WIDTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  launch_ff, launch_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_ciphertext_ff, rsp_ciphertext_in;
   logic [WORD_WIDTH-1:0] exponent_ff, exponent_in;
   logic [WORD_WIDTH-1:0] modulus_ff, modulus_in;
   logic [WORD_WIDTH-1:0] exp_bits_ff, exp_bits_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] base_ff, base_in;

   logic                  accept;
   logic                  small_modulus;
   logic                  mul_start;
   logic [WORD_WIDTH-1:0] mul_a;
   logic [WORD_WIDTH-1:0] mul_b;
   logic                  mul_done;
   logic [WORD_WIDTH-1:0] mul_product;
   logic                  sqr_done;
   logic [WORD_WIDTH-1:0] sqr_product;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign small_modulus = (modulus_ff[WORD_WIDTH-1:1] == '0);

   // idle: reduce the message as 1 * message mod modulus
   assign mul_start = (accept && !small_modulus) || launch_ff;
   assign mul_a     = (state_ff == ST_IDLE) ? WORD_WIDTH'(1) : acc_ff;
   assign mul_b     = (state_ff == ST_IDLE) ? req_message : base_ff;

   rme_modmul #(
      .WIDTH(WORD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   rme_modmul #(
      .WIDTH(WORD_WIDTH)
   ) u_sqr (
      .clock   (clock),
      .reset   (reset),
      .start   (launch_ff),
      .a       (base_ff),
      .b       (base_ff),
      .modulus (modulus_ff),
      .done    (sqr_done),
      .product (sqr_product)
   );

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rme_pkg::CSR_EXPONENT: exponent_in = csr_data;
            rme_pkg::CSR_MODULUS:  modulus_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      launch_in         = 1'b0;
      rsp_valid_in      = 1'b0;
      rsp_ciphertext_in = rsp_ciphertext_ff;
      exp_bits_in       = exp_bits_ff;
      step_in           = step_ff;
      acc_in            = acc_ff;
      base_in           = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (small_modulus) begin
                  rsp_valid_in      = 1'b1;
                  rsp_ciphertext_in = '0;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in     = mul_product;
               acc_in      = WORD_WIDTH'(1);
               exp_bits_in = exponent_ff;
               step_in     = CW'(WORD_WIDTH - 1);
               launch_in   = 1'b1;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (mul_done && sqr_done) begin
               if (exp_bits_ff[0]) begin
                  acc_in = mul_product;
               end
               base_in     = sqr_product;
               exp_bits_in = exp_bits_ff >> 1;
               if (step_ff == '0) begin
                  state_in          = ST_IDLE;
                  rsp_valid_in      = 1'b1;
                  rsp_ciphertext_in = exp_bits_ff[0] ? mul_product : acc_ff;
               end else begin
                  step_in   = step_ff - 1'b1;
                  launch_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         exponent_ff  <= WORD_WIDTH'(rme_pkg::EXPONENT_RESET);
         modulus_ff   <= WORD_WIDTH'(rme_pkg::MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ciphertext_ff <= rsp_ciphertext_in;
      exp_bits_ff       <= exp_bits_in;
      step_ff           <= step_in;
      acc_ff            <= acc_in;
      base_ff           <= base_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

endmodule

// ----- sv/rme_checker.sv -----
// Port-level checks for the modular exponentiation block, bound to the top level.
module rme_checker #(
   parameter int WORD_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [WORD_WIDTH-1:0] rsp_ciphertext
);

   // a result is only shown once the item has left the busy phase
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a started item");

   a_busy_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without an item");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_ciphertext))
      else $error("unknown bits on rsp_ciphertext");

endmodule

bind rsa_modular_exponentiation rme_checker #(
   .WORD_WIDTH(WORD_WIDTH)
) u_rme_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_ciphertext (rsp_ciphertext)
);
